// ----- rtl/bgra_cnv_pkg.sv -----
// Package with the shared types, constants and the channel rounding function.
package bgra_cnv_pkg;

	localparam int ACC_W  = 32;
	localparam int PROD_W = 27;
	localparam int COEF_W = 18;

	localparam logic CMD_COEF  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [31:0] MASK_R = 32'h00FF0000;
	localparam logic [31:0] MASK_G = 32'h0000FF00;
	localparam logic [31:0] MASK_B = 32'h000000FF;
	localparam logic [31:0] MASK_A = 32'hFF000000;

	localparam logic signed [ACC_W-1:0] SAT_HI = 32'sd1044480;

	typedef struct packed {
		logic clear;
		logic tap_v;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
	} mac_stat_t;

	// Clamp a Q.12 sum to 0..255 and round to nearest, ties to even.
	function automatic logic [7:0] round_channel(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] c;
		logic [7:0] q;
		logic [11:0] rem;
		c = s;
		if (c < 0) c = '0;
		if (c > SAT_HI) c = SAT_HI;
		q = c[19:12];
		rem = c[11:0];
		if (rem > 12'd2048 || (rem == 12'd2048 && q[0])) q = q + 8'd1;
		return q;
	endfunction

endpackage

// ----- rtl/bgra_cnv_mac.sv -----
// Three-channel multiply-accumulate datapath with result rounding.
module bgra_cnv_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bgra_cnv_pkg::mac_ctrl_t          ctrl,
	input  logic [31:0]                      pix_s1,
	input  logic signed [bgra_cnv_pkg::COEF_W-1:0] coef_s1,
	output bgra_cnv_pkg::mac_stat_t          stat,
	output logic [23:0]                      rgb
);
	import bgra_cnv_pkg::*;

	logic                     prod_v_s2;
	logic signed [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	logic signed [ACC_W-1:0]  ar_q, ag_q, ab_q;
	logic [31:0]              pm_r, pm_g, pm_b;

	assign pm_r = (pix_s1 & MASK_R) >> 16;
	assign pm_g = (pix_s1 & MASK_G) >> 8;
	assign pm_b = pix_s1 & MASK_B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
		end else begin
			prod_v_s2 <= ctrl.tap_v;
		end
	end

	always_ff @(posedge clk) begin
		pr_s2 <= PROD_W'($signed({1'b0, pm_r[7:0]}) * coef_s1);
		pg_s2 <= PROD_W'($signed({1'b0, pm_g[7:0]}) * coef_s1);
		pb_s2 <= PROD_W'($signed({1'b0, pm_b[7:0]}) * coef_s1);
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			ar_q <= '0;
			ag_q <= '0;
			ab_q <= '0;
		end else if (prod_v_s2) begin
			ar_q <= ar_q + ACC_W'(pr_s2);
			ag_q <= ag_q + ACC_W'(pg_s2);
			ab_q <= ab_q + ACC_W'(pb_s2);
		end
	end

	assign stat.busy = prod_v_s2;
	assign rgb = {round_channel(ar_q), round_channel(ag_q), round_channel(ab_q)};

endmodule

// ----- rtl/bgra_2d_convolution_filter_core.sv -----
// Top level of the BGRA 2D convolution filter: delay line, coefficient store, sequencer.
//
// Input channel (in_valid / in_stall) carries one transaction per item: cmd 0 loads
// coefficient coef_value at coef_index, cmd 1 delivers pixel_in, with frame_start
// marking the first pixel of a frame. Output channel (out_valid / out_stall) carries
// pixel_out and center_position for every center whose window lies inside the frame.
// Kernel size and row pitch are set over the APB port while the block is idle; the user
// must keep to that, as the block itself does not enforce it.
// A coefficient load is accepted without a stall and the input stays open. A pixel holds
// in_stall high through a setup state, the issue state for each kernel tap in turn, a
// center read, a drain state that waits for the accumulator and an output state. A pixel
// that emits nothing stalls the input for its setup state only. The delay line memory has
// a single read port, so the taps are read one at a time. A result waits in the output
// register while out_stall is high; the next transaction is accepted meanwhile, and its
// own result waits until the register is free.
//
// Reset sets the kernel to 3x3, the pitch to 1024 and the frame position to zero, and
// clears every coefficient valid bit so all coefficients read as zero. The delay line is
// not cleared; no read reaches an unwritten entry under the emission rule.
module bgra_2d_convolution_filter_core #(
	parameter int MAX_KERNEL    = 7,
	parameter int MAX_ROW_PITCH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [5:0]  coef_index,
	input  logic signed [17:0] coef_value,
	input  logic [31:0] pixel_in,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_out,
	output logic [23:0] center_position
);
	import bgra_cnv_pkg::*;

	localparam int DEPTH = 2 * ((MAX_KERNEL / 2) * MAX_ROW_PITCH + MAX_KERNEL / 2) + 1;
	localparam int DAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int CIW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam logic [2:0] KMAX3 = 3'((MAX_KERNEL > 7) ? 7 : MAX_KERNEL);
	localparam logic [10:0] PMAX11 = 11'((MAX_ROW_PITCH > 2047) ? 2047 : MAX_ROW_PITCH);

	localparam logic [1:0] REG_KW = 2'd0;
	localparam logic [1:0] REG_KH = 2'd1;
	localparam logic [1:0] REG_RP = 2'd2;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_ISSUE  = 3'd2;
	localparam logic [2:0] ST_CENTER = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	function automatic logic [DAW-1:0] add_mod(input logic [DAW-1:0] a, input logic [DAW-1:0] b);
		logic [DAW:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= (DAW+1)'(DEPTH)) t = t - (DAW+1)'(DEPTH);
		return t[DAW-1:0];
	endfunction

	function automatic logic [DAW-1:0] sub_mod(input logic [DAW-1:0] a, input logic [DAW-1:0] b);
		logic [DAW:0] t;
		if (a >= b) t = {1'b0, a} - {1'b0, b};
		else t = {1'b0, a} + (DAW+1)'(DEPTH) - {1'b0, b};
		return t[DAW-1:0];
	endfunction

	// Configuration registers.
	logic [2:0]  kw_reg_q, kh_reg_q;
	logic [10:0] rp_reg_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_reg_q <= 3'd3;
			kh_reg_q <= 3'd3;
			rp_reg_q <= 11'd1024;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_KW:  kw_reg_q <= pwdata[2:0];
				REG_KH:  kh_reg_q <= pwdata[2:0];
				REG_RP:  rp_reg_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_KW:  prdata = {29'd0, kw_reg_q};
			REG_KH:  prdata = {29'd0, kh_reg_q};
			REG_RP:  prdata = {21'd0, rp_reg_q};
			default: prdata = '0;
		endcase
	end

	// Sequencer state.
	logic [2:0]     state_q;
	logic [DAW-1:0] wp_q, rd_addr_q, row_addr_q, ctr_addr_q;
	logic [23:0]    fpos_q, p_q, ctr_pos_q;
	logic [2:0]     kw_q, kh_q, c_q, r_q;
	logic [10:0]    pitch_q;
	logic [CIW-1:0] k_q;
	logic           tap_v_s1, ctr_v_s1;
	logic [7:0]     alpha_q;
	logic           out_v_q;
	logic [31:0]    pix_out_q;
	logic [23:0]    pos_out_q;

	logic           acc_in, acc_pix, acc_coef;
	logic [2:0]     kw_eff, kh_eff;
	logic [10:0]    pitch_eff;
	logic [12:0]    row_off;
	logic [DAW-1:0] hs, span2;
	logic [23:0]    p_now;
	logic           out_free;

	assign acc_in   = in_valid && !in_stall;
	assign acc_pix  = acc_in && (cmd == CMD_PIXEL);
	assign acc_coef = acc_in && (cmd == CMD_COEF);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_v_q || !out_stall;

	assign kw_eff = (kw_reg_q == 3'd0) ? 3'd1 : ((kw_reg_q > KMAX3) ? KMAX3 : kw_reg_q);
	assign kh_eff = (kh_reg_q == 3'd0) ? 3'd1 : ((kh_reg_q > KMAX3) ? KMAX3 : kh_reg_q);
	assign pitch_eff = (rp_reg_q > PMAX11) ? PMAX11 : rp_reg_q;
	assign p_now = frame_start ? 24'd0 : fpos_q;

	assign row_off = 13'(kh_q[2:1]) * 13'(pitch_q);
	assign hs = DAW'(row_off) + DAW'(kw_q[2:1]);
	assign span2 = DAW'({hs, 1'b0});

	// Memories.
	logic [31:0]       dly_mem [DEPTH];
	logic [31:0]       pix_s1;
	logic [COEF_W-1:0] coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0] coef_vld_q;
	logic [COEF_W-1:0] coef_rd_s1;
	logic              coef_ok_s1;
	logic [DAW-1:0]    mem_raddr;
	logic              coef_wr;

	assign mem_raddr = (state_q == ST_CENTER) ? ctr_addr_q : rd_addr_q;
	assign coef_wr = acc_coef && (32'(coef_index) < COEF_DEPTH);

	always_ff @(posedge clk) begin
		if (acc_pix) dly_mem[wp_q] <= pixel_in;
		if (state_q == ST_ISSUE || state_q == ST_CENTER) pix_s1 <= dly_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_wr) coef_mem[CIW'(coef_index)] <= coef_value;
		coef_rd_s1 <= coef_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			coef_ok_s1 <= 1'b0;
		end else begin
			if (coef_wr) coef_vld_q[CIW'(coef_index)] <= 1'b1;
			coef_ok_s1 <= coef_vld_q[k_q];
		end
	end

	// Multiply-accumulate datapath.
	mac_ctrl_t mac_ctrl;
	mac_stat_t mac_stat;
	logic [23:0] rgb;

	assign mac_ctrl.clear = (state_q == ST_SETUP);
	assign mac_ctrl.tap_v = tap_v_s1;

	bgra_cnv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.pix_s1 (pix_s1),
		.coef_s1(coef_ok_s1 ? $signed(coef_rd_s1) : '0),
		.stat   (mac_stat),
		.rgb    (rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			fpos_q   <= '0;
			tap_v_s1 <= 1'b0;
			ctr_v_s1 <= 1'b0;
			c_q      <= '0;
			r_q      <= '0;
			k_q      <= '0;
		end else begin
			tap_v_s1 <= (state_q == ST_ISSUE);
			ctr_v_s1 <= (state_q == ST_CENTER);
			unique case (state_q)
				ST_IDLE: begin
					if (acc_pix) begin
						p_q     <= p_now;
						fpos_q  <= p_now + 24'd1;
						kw_q    <= kw_eff;
						kh_q    <= kh_eff;
						pitch_q <= pitch_eff;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					// The pixel just written sits at wp_q; the write pointer moves on here.
					wp_q <= add_mod(wp_q, DAW'(1));
					if (p_q >= 24'(span2)) begin
						rd_addr_q  <= sub_mod(wp_q, span2);
						row_addr_q <= sub_mod(wp_q, span2);
						ctr_addr_q <= sub_mod(wp_q, hs);
						ctr_pos_q  <= p_q - 24'(hs);
						c_q        <= '0;
						r_q        <= '0;
						k_q        <= '0;
						state_q    <= ST_ISSUE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					if (c_q == kw_q - 3'd1) begin
						if (r_q == kh_q - 3'd1) begin
							state_q <= ST_CENTER;
						end else begin
							r_q        <= r_q + 3'd1;
							c_q        <= '0;
							k_q        <= k_q + CIW'(1);
							row_addr_q <= add_mod(row_addr_q, DAW'(pitch_q));
							rd_addr_q  <= add_mod(row_addr_q, DAW'(pitch_q));
						end
					end else begin
						c_q       <= c_q + 3'd1;
						k_q       <= k_q + CIW'(1);
						rd_addr_q <= add_mod(rd_addr_q, DAW'(1));
					end
				end
				ST_CENTER: state_q <= ST_DRAIN;
				ST_DRAIN: begin
					if (!tap_v_s1 && !mac_stat.busy) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctr_v_s1) alpha_q <= pix_s1[31:24];
		if (state_q == ST_FIN && out_free) begin
			pix_out_q <= {alpha_q, rgb};
			pos_out_q <= ctr_pos_q;
		end
	end

	assign out_valid       = out_v_q;
	assign pixel_out       = pix_out_q;
	assign center_position = pos_out_q;

	a_tap_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		tap_v_s1 |-> $past(state_q == ST_ISSUE))
		else $error("tap data without an issue cycle");

	a_fin_idle_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!mac_stat.busy && !tap_v_s1))
		else $error("result taken while accumulation pending");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (32'(rd_addr_q) < DEPTH && 32'(k_q) < COEF_DEPTH))
		else $error("read address out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |=> (out_v_q && $stable(pix_out_q)))
		else $error("stalled result overwritten");

endmodule

// ----- dv/bgra_2d_convolution_filter_core_checker.sv -----
// Checker for the BGRA 2D convolution filter core: predicts every result and compares it.
`timescale 1ns / 100ps

module bgra_2d_convolution_filter_core_checker
	import bgra_cnv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [5:0]  coef_index,
	input  logic signed [17:0] coef_value,
	input  logic [31:0] pixel_in,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] pixel_out,
	input  logic [23:0] center_position,
	output int          fail_count,
	output int          pending
);

	localparam int KMAX       = 7;
	localparam int PITCH_MAX  = 1024;
	localparam int TAPS       = KMAX * KMAX;
	localparam int LINE_DEPTH = 2 * ((KMAX / 2) * PITCH_MAX + KMAX / 2) + 1;

	localparam logic [1:0] REG_KW    = 2'd0;
	localparam logic [1:0] REG_KH    = 2'd1;
	localparam logic [1:0] REG_PITCH = 2'd2;

	typedef struct packed {
		logic [31:0] pix;
		logic [23:0] pos;
	} filtered_t;

	logic [2:0]         cfg_kw;
	logic [2:0]         cfg_kh;
	logic [10:0]        cfg_pitch;
	logic signed [17:0] taps [0:TAPS-1];
	logic [31:0]        history [0:LINE_DEPTH-1];
	int                 hist_wp;
	logic [23:0]        next_pos;
	filtered_t          filtered_q [$];

	function automatic logic [7:0] clamp_round(input logic signed [47:0] s);
		logic signed [47:0] c;
		logic [7:0] q;
		c = s;
		if (c < 0) c = '0;
		if (c > 48'sd1044480) c = 48'sd1044480;
		q = c[19:12];
		if (c[11:0] > 12'd2048 || (c[11:0] == 12'd2048 && q[0])) q = q + 8'd1;
		return q;
	endfunction

	task automatic filter_pixel(input logic [31:0] pix, input logic fs);
		int kw, kh, pitch, half, span2, p, lag, idx;
		logic signed [47:0] sr, sg, sb;
		logic [31:0] px, ctr;
		filtered_t res;
		if (fs) next_pos = '0;
		p = next_pos;
		next_pos = next_pos + 24'd1;
		history[hist_wp] = pix;
		kw = (cfg_kw == 0) ? 1 : cfg_kw;
		kh = (cfg_kh == 0) ? 1 : cfg_kh;
		pitch = (cfg_pitch > PITCH_MAX) ? PITCH_MAX : cfg_pitch;
		half = (kh / 2) * pitch + kw / 2;
		span2 = 2 * half;
		if (p >= span2) begin
			sr = 0;
			sg = 0;
			sb = 0;
			for (int r = 0; r < kh; r++) begin
				for (int c = 0; c < kw; c++) begin
					lag = span2 - (r * pitch + c);
					idx = (hist_wp + LINE_DEPTH - lag) % LINE_DEPTH;
					px = history[idx];
					sr += $signed({40'd0, px[23:16]}) * taps[r * kw + c];
					sg += $signed({40'd0, px[15:8]}) * taps[r * kw + c];
					sb += $signed({40'd0, px[7:0]}) * taps[r * kw + c];
				end
			end
			ctr = history[(hist_wp + LINE_DEPTH - half) % LINE_DEPTH];
			res.pix = {ctr[31:24], clamp_round(sr), clamp_round(sg), clamp_round(sb)};
			res.pos = 24'(p - half);
			filtered_q.push_back(res);
		end
		hist_wp = (hist_wp + 1) % LINE_DEPTH;
	endtask

	initial begin
		for (int i = 0; i < LINE_DEPTH; i++) history[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		filtered_t exp_res;
		if (!arst_n) begin
			cfg_kw = 3'd3;
			cfg_kh = 3'd3;
			cfg_pitch = 11'd1024;
			for (int i = 0; i < TAPS; i++) taps[i] = '0;
			hist_wp = 0;
			next_pos = '0;
			fail_count = 0;
			filtered_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: pixel_out %h center_position %0d",
						pixel_out, center_position);
					fail_count++;
				end else begin
					exp_res = filtered_q.pop_front();
					if (pixel_out !== exp_res.pix) begin
						$error("pixel_out: expected %h, actual %h", exp_res.pix, pixel_out);
						fail_count++;
					end
					if (center_position !== exp_res.pos) begin
						$error("center_position: expected %0d, actual %0d",
							exp_res.pos, center_position);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_COEF) begin
					if (coef_index < TAPS) taps[coef_index] = coef_value;
				end else begin
					filter_pixel(pixel_in, frame_start);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_KW:    cfg_kw = pwdata[2:0];
					REG_KH:    cfg_kh = pwdata[2:0];
					REG_PITCH: cfg_pitch = pwdata[10:0];
					default: ;
				endcase
			end
			pending = filtered_q.size();
		end
	end

endmodule

// ----- dv/bgra_2d_convolution_filter_core_test.sv -----
// Testbench top for the BGRA 2D convolution filter core: stimulus, idling and verdict.
`timescale 1ns / 100ps

module bgra_2d_convolution_filter_core_test;
	import bgra_cnv_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int DRAIN_WAIT = 80;

	localparam logic [3:0] ADDR_KW    = 4'd0;
	localparam logic [3:0] ADDR_KH    = 4'd4;
	localparam logic [3:0] ADDR_PITCH = 4'd8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = CMD_PIXEL;
	logic [5:0]  coef_index = '0;
	logic signed [17:0] coef_value = '0;
	logic [31:0] pixel_in = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] pixel_out;
	logic [23:0] center_position;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	bgra_2d_convolution_filter_core DUT (.*);

	bgra_2d_convolution_filter_core_checker checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Watchdog on cycles in which no transaction moves on any port.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("** bgra_2d_convolution_filter_core: FAILED **");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send(input logic c, input logic [5:0] idx, input logic [17:0] val,
		input logic [31:0] pix, input logic fs);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cmd <= c;
		coef_index <= idx;
		coef_value <= val;
		pixel_in <= pix;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_coef(input logic [5:0] idx, input logic [17:0] val);
		send(CMD_COEF, idx, val, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic send_pixel(input logic [31:0] pix, input logic fs);
		send(CMD_PIXEL, 6'($urandom), 18'($urandom), pix, fs);
	endtask

	task automatic settle_and_configure(input int kw, input int kh, input int pitch);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		reg_write(ADDR_KW, kw);
		reg_write(ADDR_KH, kh);
		reg_write(ADDR_PITCH, pitch);
	endtask

	task automatic random_phase(input int n, input int fs_per_mille);
		logic [17:0] v;
		send_pixel($urandom, 1'b1);
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(99) < 8) begin
				v = $urandom_range(1) ? 18'($urandom) : 18'($signed($urandom_range(16384)) - 8192);
				load_coef(($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(48)), v);
			end else begin
				send_pixel($urandom, $urandom_range(999) < fs_per_mille);
			end
		end
	endtask

	initial begin
		int kws [7] = '{3, 7, 0, 5, 2, 7, 1};
		int khs [7] = '{3, 7, 0, 2, 7, 1, 3};
		int pitches [7] = '{16, 9, 0, 1, 0, 1024, 2047};
		int counts [7] = '{200, 200, 200, 200, 200, 200, 400};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		settle_and_configure(kws[0], khs[0], pitches[0]);
		// Directed: identity kernel, coefficient extremes, ignored indexes, pixel extremes.
		load_coef(6'd4, 18'sd4096);
		send_pixel(32'hFFFFFFFF, 1'b1);
		send_pixel(32'h00000000, 1'b0);
		load_coef(6'd63, 18'sd5);
		load_coef(6'd49, 18'sd7);
		load_coef(6'd48, -18'sd1);
		for (int i = 0; i < 40; i++) send_pixel((i % 2) ? 32'hFFFFFFFF : 32'h80808080, 1'b0);
		load_coef(6'd0, 18'sd131071);
		load_coef(6'd8, -18'sd131072);
		load_coef(6'd1, 18'sd2048);
		for (int i = 0; i < 20; i++) send_pixel((i % 3) ? 32'h01030507 : 32'hFF000000, 1'b0);
		send_pixel($urandom, 1'b1);

		for (int ph = 0; ph < 7; ph++) begin
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 26 : 52) : 0;
			recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 26 : 52) : 0;
			if (ph != 0) settle_and_configure(kws[ph], khs[ph], pitches[ph]);
			random_phase(counts[ph], (ph == 6) ? 0 : 4);
		end

		in_valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("** bgra_2d_convolution_filter_core: PASSED **");
		else
			$display("** bgra_2d_convolution_filter_core: FAILED **");
		$finish;
	end

endmodule
